@@ rtl/sfc_pkg.sv @@
package sfc_pkg;

  localparam int FRAME_BYTES = 50;

  localparam logic [15:0] CRC_START = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h8408;
  localparam logic [7:0] HEADER_RESET = 8'h5A;

  localparam logic [7:0] POS_MAX = 8'hFF;
  localparam logic [7:0] LAST_POS = 8'(FRAME_BYTES - 1);
  localparam logic [7:0] CRC_END_POS = 8'(FRAME_BYTES - 2);

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
  localparam logic [QUEUE_AW:0] QUEUE_FULL = (QUEUE_AW + 1)'(QUEUE_DEPTH);

  localparam int CFG_AW = 1;
  localparam int CFG_DW = 8;
  localparam logic [CFG_AW-1:0] REG_CRC_ENABLE = 1'b0;
  localparam logic [CFG_AW-1:0] REG_HEADER = 1'b1;

  typedef enum logic [1:0] {
    STATUS_ACCEPTED  = 2'd0,
    STATUS_BAD_LEN   = 2'd1,
    STATUS_BAD_HDR   = 2'd2,
    STATUS_CRC_ERROR = 2'd3
  } status_t;

  // Frame summary handed from the byte front end to the status back end
  typedef struct packed {
    logic len_bad;
    logic hdr_bad;
    logic crc_bad;
  } verdict_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/sfc_if.sv @@
interface sfc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface sfc_result_if import sfc_pkg::*; ();
  logic        valid;
  logic        ready;
  status_t     frame_status;
  logic [31:0] received_count;
  logic [31:0] invalid_count;
  logic [31:0] crc_error_count;

  modport source (output valid, output frame_status, output received_count,
                  output invalid_count, output crc_error_count, input ready);
  modport sink (input valid, input frame_status, input received_count,
                input invalid_count, input crc_error_count, output ready);
endinterface

@@ rtl/sfc_front.sv @@
module sfc_front import sfc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  header_value,
  sfc_byte_if.sink    in_byte,
  input  logic        q_full,
  output logic        q_push,
  output verdict_t    q_data
);

  logic [15:0] running_crc;
  logic [15:0] running_crc_next;
  logic [7:0]  byte_position;
  logic        header_matched;
  logic        header_matched_next;
  logic [15:0] tail_bytes;
  logic [15:0] tail_bytes_next;
  logic        accept;

  assign in_byte.ready = !q_full;
  assign accept = in_byte.valid && in_byte.ready;

  always_comb begin
    header_matched_next = (byte_position == 8'd0) ? (in_byte.data_byte == header_value)
                                                  : header_matched;
    running_crc_next = (byte_position < CRC_END_POS)
                       ? crc_update(running_crc, in_byte.data_byte) : running_crc;
    tail_bytes_next = {in_byte.data_byte, tail_bytes[15:8]};
  end

  assign q_push = accept && in_byte.last_byte;
  assign q_data = '{len_bad: byte_position != LAST_POS,
                    hdr_bad: !header_matched_next,
                    crc_bad: running_crc_next != tail_bytes_next};

  always_ff @(posedge clk) begin
    if (rst || q_push) begin
      running_crc    <= CRC_START;
      byte_position  <= 8'd0;
      header_matched <= 1'b0;
      tail_bytes     <= 16'h0000;
    end else if (accept) begin
      running_crc    <= running_crc_next;
      header_matched <= header_matched_next;
      tail_bytes     <= tail_bytes_next;
      // hold at the top so an overlong message never matches the frame length
      if (byte_position != POS_MAX) begin
        byte_position <= byte_position + 8'd1;
      end
    end
  end

endmodule

@@ rtl/sfc_queue.sv @@
module sfc_queue import sfc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  verdict_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output verdict_t head
);

  verdict_t              entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     count;

  assign full = (count == QUEUE_FULL);
  assign not_empty = (count != '0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/sfc_back.sv @@
module sfc_back import sfc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        crc_check_enable,
  input  logic        q_not_empty,
  input  verdict_t    q_head,
  output logic        q_pop,
  sfc_result_if.source out_res
);

  logic        out_valid;
  status_t     frame_status;
  status_t     status_next;
  logic [31:0] accepted_total;
  logic [31:0] bad_header_total;
  logic [31:0] crc_fail_total;

  assign q_pop = q_not_empty && (!out_valid || out_res.ready);

  always_comb begin
    if (q_head.len_bad) begin
      status_next = STATUS_BAD_LEN;
    end else if (q_head.hdr_bad) begin
      status_next = STATUS_BAD_HDR;
    end else if (crc_check_enable && q_head.crc_bad) begin
      status_next = STATUS_CRC_ERROR;
    end else begin
      status_next = STATUS_ACCEPTED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid        <= 1'b0;
      frame_status     <= STATUS_ACCEPTED;
      accepted_total   <= 32'd0;
      bad_header_total <= 32'd0;
      crc_fail_total   <= 32'd0;
    end else if (q_pop) begin
      out_valid    <= 1'b1;
      frame_status <= status_next;
      case (status_next)
        STATUS_ACCEPTED:  accepted_total <= accepted_total + 32'd1;
        STATUS_BAD_HDR:   bad_header_total <= bad_header_total + 32'd1;
        STATUS_CRC_ERROR: crc_fail_total <= crc_fail_total + 32'd1;
        default:          ;
      endcase
    end else if (out_res.ready) begin
      out_valid <= 1'b0;
    end
  end

  // counts change only when a new result is loaded, so they hold under stall
  assign out_res.valid           = out_valid;
  assign out_res.frame_status    = frame_status;
  assign out_res.received_count  = accepted_total;
  assign out_res.invalid_count   = bad_header_total;
  assign out_res.crc_error_count = crc_fail_total;

`ifndef SYNTHESIS
  a_counts_idle: assert property (@(posedge clk) disable iff (rst)
    !q_pop |=> $stable(accepted_total) && $stable(bad_header_total) && $stable(crc_fail_total))
    else $error("counter moved without a frame");

  a_bad_len_no_count: assert property (@(posedge clk) disable iff (rst)
    q_pop && q_head.len_bad
      |=> $stable(accepted_total) && $stable(bad_header_total) && $stable(crc_fail_total))
    else $error("wrong-length frame changed a counter");

  a_accept_counts: assert property (@(posedge clk) disable iff (rst)
    q_pop && !q_head.len_bad && !q_head.hdr_bad && !q_head.crc_bad
      |=> frame_status == STATUS_ACCEPTED && accepted_total == $past(accepted_total) + 32'd1)
    else $error("clean frame not counted as accepted");

  a_hdr_first: assert property (@(posedge clk) disable iff (rst)
    q_pop && !q_head.len_bad && q_head.hdr_bad |=> frame_status == STATUS_BAD_HDR)
    else $error("header check not given priority");
`endif

endmodule

@@ rtl/serial_frame_crc16_checker.sv @@
// The earliest status transaction follows the edge that accepts the flagged last byte
// through the queue write and then the output register load.
// Throughput: one byte per cycle; the byte-wide CRC update is combinational. Input
// stalls only while the 4-entry frame summary queue is full behind a stalled result.
// Reset (rst, synchronous): clears frame state and all counts, CRC check enabled,
// expected header 0x5A.
module serial_frame_crc16_checker import sfc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  sfc_byte_if.sink          in_byte,
  sfc_result_if.source      out_res
);

  logic       crc_check_enable;
  logic [7:0] header_value;
  logic       q_full;
  logic       q_push;
  verdict_t   q_data;
  logic       q_pop;
  logic       q_not_empty;
  verdict_t   q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_check_enable <= 1'b1;
      header_value     <= HEADER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CRC_ENABLE: crc_check_enable <= cfg_data[0];
        REG_HEADER:     header_value <= cfg_data[7:0];
      endcase
    end
  end

  sfc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .header_value (header_value),
    .in_byte      (in_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_data)
  );

  sfc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  sfc_back u_back (
    .clk              (clk),
    .rst              (rst),
    .crc_check_enable (crc_check_enable),
    .q_not_empty      (q_not_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_res          (out_res)
  );

endmodule

@@ test/tb_serial_frame_crc16_checker.sv @@
`timescale 1ns / 100ps

module tb_serial_frame_crc16_checker;
  import sfc_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_BYTES = 200;
  localparam int MIN_FRAMES = 48;

  typedef enum int {
    MSG_GOOD,
    MSG_BAD_HEADER,
    MSG_BAD_CRC,
    MSG_ODD_LENGTH,
    MSG_LONG
  } msg_kind_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] ok_total;
    logic [31:0] hdr_total;
    logic [31:0] crc_total;
  } frame_report_t;

  class crc_frame_board;
    logic          crc_on;
    logic [7:0]    header_cfg;
    logic [15:0]   crc;
    logic [7:0]    pos;
    bit            hdr_ok;
    logic [15:0]   tail;
    logic [31:0]   ok_total;
    logic [31:0]   hdr_total;
    logic [31:0]   crc_total;
    frame_report_t reports[$];
    int            errors;
    int            bytes_seen;
    int            frames_closed;

    function new();
      crc_on = 1'b1;
      header_cfg = 8'h5A;
      ok_total = '0;
      hdr_total = '0;
      crc_total = '0;
      errors = 0;
      bytes_seen = 0;
      frames_closed = 0;
      clear_frame();
    endfunction

    // Reflected CRC-16, shifted one data bit at a time, LSB first
    static function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
      logic fb;
      for (int i = 0; i < 8; i++) begin
        fb = c[0] ^ b[i];
        c = c >> 1;
        if (fb) c = c ^ 16'h8408;
      end
      return c;
    endfunction

    function void clear_frame();
      crc = 16'hFFFF;
      pos = '0;
      hdr_ok = 1'b0;
      tail = '0;
    endfunction

    function void set_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] v);
      if (idx == REG_CRC_ENABLE) crc_on = v[0];
      else if (idx == REG_HEADER) header_cfg = v;
    endfunction

    function int pending();
      return reports.size();
    endfunction

    function void absorb_byte(logic [7:0] b, logic is_last);
      int len;
      frame_report_t r;
      bytes_seen++;
      if (pos == 8'd0) hdr_ok = (b == header_cfg);
      if (int'(pos) < FRAME_BYTES - 2) crc = crc_next(crc, b);
      tail = {b, tail[15:8]};
      len = int'(pos) + 1;
      if (pos != 8'hFF) pos++;
      if (!is_last) return;
      if (len != FRAME_BYTES) begin
        r.status = STATUS_BAD_LEN;
      end else if (!hdr_ok) begin
        r.status = STATUS_BAD_HDR;
        hdr_total++;
      end else if (crc_on && crc != tail) begin
        r.status = STATUS_CRC_ERROR;
        crc_total++;
      end else begin
        r.status = STATUS_ACCEPTED;
        ok_total++;
      end
      r.ok_total = ok_total;
      r.hdr_total = hdr_total;
      r.crc_total = crc_total;
      reports.push_back(r);
      frames_closed++;
      clear_frame();
    endfunction

    function void check_report(status_t s, logic [31:0] ok_n, logic [31:0] hdr_n,
                               logic [31:0] crc_n);
      frame_report_t r;
      if (reports.size() == 0) begin
        $error("unexpected status transaction: frame_status %s", s.name());
        errors++;
        return;
      end
      r = reports.pop_front();
      if (s !== r.status) begin
        $error("frame_status: expected %s, got %s", r.status.name(), s.name());
        errors++;
      end
      if (ok_n !== r.ok_total) begin
        $error("received_count: expected %0d, got %0d", r.ok_total, ok_n);
        errors++;
      end
      if (hdr_n !== r.hdr_total) begin
        $error("invalid_count: expected %0d, got %0d", r.hdr_total, hdr_n);
        errors++;
      end
      if (crc_n !== r.crc_total) begin
        $error("crc_error_count: expected %0d, got %0d", r.crc_total, crc_n);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  sfc_byte_if   byte_ch ();
  sfc_result_if res_ch ();

  serial_frame_crc16_checker u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_byte   (byte_ch),
    .out_res   (res_ch)
  );

  crc_frame_board board = new();

  int burst_left = 0;
  int gap_max = 3;
  int hold_asked = 0;
  int hold_done = 0;
  int cycles = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("** serial_frame_crc16_checker: FAILED **");
      $finish;
    end
  end

  // Result side: check accepted transactions, stall on a pattern of its own
  initial begin : result_sink
    int mode;
    int mode_left;
    int hold_left;
    int phase_cnt;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    phase_cnt = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready)
        board.check_report(res_ch.frame_status, res_ch.received_count,
                           res_ch.invalid_count, res_ch.crc_error_count);
      phase_cnt++;
      if (hold_done < hold_asked) begin
        if (hold_left == 0) hold_left = HOLD_CYCLES;
        res_ch.ready <= 1'b0;
        hold_left--;
        if (hold_left == 0) hold_done++;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (mode)
          0: res_ch.ready <= 1'b1;
          1: res_ch.ready <= ($urandom_range(0, 1) == 1);
          2: res_ch.ready <= ($urandom_range(0, 3) == 0);
          default: res_ch.ready <= phase_cnt[0];
        endcase
      end
    end
  end

  task automatic send_item(logic [7:0] b, logic is_last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        byte_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    byte_ch.valid <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.last_byte <= is_last;
    do @(posedge clk); while (!byte_ch.ready);
    board.absorb_byte(b, is_last);
  endtask

  task automatic wait_drained();
    byte_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(logic [CFG_DW-1:0] en_val, logic [CFG_DW-1:0] hdr_val);
    cfg_we <= 1'b1;
    cfg_index <= REG_CRC_ENABLE;
    cfg_data <= en_val;
    @(posedge clk);
    board.set_reg(REG_CRC_ENABLE, en_val);
    cfg_index <= REG_HEADER;
    cfg_data <= hdr_val;
    @(posedge clk);
    board.set_reg(REG_HEADER, hdr_val);
    cfg_we <= 1'b0;
  endtask

  task automatic send_message(msg_kind_t kind);
    logic [7:0]  msg[$];
    logic [15:0] c;
    int          n;
    case (kind)
      MSG_GOOD, MSG_BAD_HEADER, MSG_BAD_CRC: begin
        msg.push_back(board.header_cfg);
        for (int i = 1; i < FRAME_BYTES - 2; i++) msg.push_back(8'($urandom));
        if (kind == MSG_BAD_HEADER) msg[0] = msg[0] ^ 8'($urandom_range(1, 255));
        c = 16'hFFFF;
        foreach (msg[i]) c = crc_frame_board::crc_next(c, msg[i]);
        if (kind == MSG_BAD_CRC) c = c ^ 16'($urandom_range(1, 65535));
        // checksum travels low byte first
        msg.push_back(c[7:0]);
        msg.push_back(c[15:8]);
      end
      default: begin
        if (kind == MSG_LONG) n = 256 + $urandom_range(0, 8);
        else if ($urandom_range(0, 1) == 1) n = $urandom_range(1, 8);
        else n = $urandom_range(FRAME_BYTES - 4, FRAME_BYTES + 4);
        msg.push_back(($urandom_range(0, 1) == 1) ? board.header_cfg : 8'($urandom));
        for (int i = 1; i < n; i++) msg.push_back(8'($urandom));
      end
    endcase
    foreach (msg[i]) send_item(msg[i], i == msg.size() - 1);
  endtask

  function automatic msg_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return MSG_GOOD;
    if (r < 62) return MSG_BAD_HEADER;
    if (r < 74) return MSG_BAD_CRC;
    return MSG_ODD_LENGTH;
  endfunction

  task automatic run_phase(bit do_write, logic [CFG_DW-1:0] en_val,
                           logic [CFG_DW-1:0] hdr_val, int gap_lim, bit squeeze,
                           bit with_long);
    int start;
    wait_drained();
    if (do_write) write_regs(en_val, hdr_val);
    gap_max = gap_lim;
    start = board.bytes_seen;
    send_message(MSG_GOOD);
    send_message(MSG_BAD_HEADER);
    send_message(MSG_BAD_CRC);
    if (with_long) send_message(MSG_LONG);
    if (squeeze) begin
      // hold the result side off and keep offering one-byte messages
      hold_asked++;
      repeat (16) send_item(8'($urandom), 1'b1);
    end
    while (board.bytes_seen - start < PHASE_BYTES) send_message(pick_kind());
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_CRC_ENABLE;
    cfg_data <= '0;
    byte_ch.valid <= 1'b0;
    byte_ch.data_byte <= '0;
    byte_ch.last_byte <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // short messages: extreme bytes, flagged and unflagged
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b1);
    send_item(8'h5A, 1'b0);
    send_item(8'hA5, 1'b1);
    send_item(8'h55, 1'b0);
    send_item(8'hAA, 1'b0);
    send_item(8'h0F, 1'b1);
    send_item(8'h5A, 1'b0);
    send_item(8'hF0, 1'b1);

    run_phase(1'b0, 8'h00, 8'h00, 3, 1'b0, 1'b0);
    run_phase(1'b1, 8'hFE, 8'h00, 6, 1'b1, 1'b0);
    run_phase(1'b1, 8'h01, 8'hFF, 0, 1'b0, 1'b1);
    run_phase(1'b1, {7'($urandom), 1'b1}, 8'($urandom), 10, 1'b0, 1'b0);
    run_phase(1'b1, 8'h00, 8'h5A, 2, 1'b0, 1'b0);

    while (board.frames_closed < MIN_FRAMES) send_message(MSG_ODD_LENGTH);

    wait_drained();
    repeat (8) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("** serial_frame_crc16_checker: PASSED **");
    end else begin
      $display("** serial_frame_crc16_checker: FAILED **");
    end
    $finish;
  end

endmodule
